/* hdl/bole_pkg.sv */
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types and constants for the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 64;
  localparam int unsigned WORD_W           = 32;
  localparam int unsigned POS_W            = 16;
  localparam int unsigned COUNT_W          = 7;

  typedef enum logic [1:0] {
    OP_APPEND      = 2'd0,
    OP_REMOVE_LAST = 2'd1,
    OP_FIND_REMOVE = 2'd2,
    OP_INSERT      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Command broadcast to every cell during the apply cycle
  typedef struct packed {
    logic insert;  // open a slot at the insert index and load the new word
    logic remove;  // close the gap at the first matching entry
  } cell_cmd_t;

endpackage

/* hdl/bole_cell.sv */
// ----------------------------------------------------------------------------
// bole_cell
// One list slot: holds a word, compares it against the search key, and
// shifts towards either neighbour on insert or remove.
// ----------------------------------------------------------------------------
module bole_cell
  import bole_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 6,
  parameter int unsigned CW  = 7
) (
  input  logic              clk_i,
  input  cell_cmd_t         cmd_i,
  input  logic [IW-1:0]     ins_idx_i,
  input  logic [CW-1:0]     len_i,
  input  logic [WORD_W-1:0] key_i,
  input  logic [WORD_W-1:0] load_i,
  input  logic [WORD_W-1:0] left_i,
  input  logic [WORD_W-1:0] right_i,
  input  logic              found_i,
  input  logic [WORD_W-1:0] tap_i,
  output logic [WORD_W-1:0] data_o,
  output logic              found_o,
  output logic [WORD_W-1:0] tap_o
);

  localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
  localparam logic [CW-1:0] MY_IDX_C = CW'(IDX);

  logic [WORD_W-1:0] data_q, data_d;
  logic              match_q, match_d;
  logic              last_q, last_d;

  // Occupied slots only; the rear slot flags itself for remove last
  assign match_d = (data_q == key_i) && (MY_IDX_C < len_i);
  assign last_d  = (MY_IDX_C == (len_i - CW'(1)));

  assign found_o = found_i | match_q;
  assign tap_o   = tap_i | (last_q ? data_q : '0);
  assign data_o  = data_q;

  always_comb begin
    data_d = data_q;
    if (cmd_i.insert) begin
      if (MY_IDX > ins_idx_i) begin
        data_d = left_i;
      end else if (MY_IDX == ins_idx_i) begin
        data_d = load_i;
      end
    end else if (cmd_i.remove && found_o) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
    last_q  <= last_d;
  end

endmodule

/* hdl/bounded_ordered_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_unit
// Ordered list of signed words held in a row of cells; append, remove last,
// find and remove, and insert at a 1-based position, one status per request.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata                                   tuser
//  s_axis    in   [31:0] value, [47:32] position          [1:0] op
//  m_axis    out  [31:0] removed_value, [38:32] count     [1:0] status
//
//  A request is handled in its accept cycle, which latches the compare result
//  in every cell, and then in the apply cycle, which shifts the row and loads
//  the result register; no request is accepted during the apply cycle.
//  Reset empties the list at once; slot contents are not cleared.
//  A result waiting in the output register stalls the next request only
//  until it is taken; a request may be accepted in the cycle it leaves.
//
module bounded_ordered_list_engine_unit
  import bole_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // value[31:0], position[47:32]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // removed_value[31:0], entry_count[38:32]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     len_q;
  op_e               op_q;
  logic [WORD_W-1:0] value_q;
  logic [IW-1:0]     idx_q;

  logic              out_valid_q;
  logic [WORD_W-1:0] removed_q;
  status_e           status_q;
  logic [COUNT_W-1:0] count_q;

  logic [WORD_W-1:0] in_value;
  logic [POS_W-1:0]  in_pos;
  logic              in_fire;
  logic              out_fire;

  logic [31:0]       pos_ext, len_ext, raw_idx, clamp_idx;
  cell_cmd_t         cmd;

  logic [WORD_W-1:0] cell_data [CAPACITY];
  logic              found_chain [CAPACITY+1];
  logic [WORD_W-1:0] tap_chain [CAPACITY+1];

  logic              is_full, is_empty, found_any;
  logic [CW-1:0]     len_d;
  status_e           status_d;
  logic [WORD_W-1:0] removed_d;
  logic [CW+COUNT_W-1:0] len_wide;

  assign in_value = s_axis_tdata[WORD_W-1:0];
  assign in_pos   = s_axis_tdata[WORD_W+POS_W-1:WORD_W];

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;

  // Append always lands at the rear; for insert, position 0 or 1 means
  // front and anything past the end appends
  assign pos_ext   = 32'(in_pos);
  assign len_ext   = 32'(len_q);
  assign raw_idx   = (s_axis_tuser == OP_APPEND) ? len_ext :
                     (pos_ext <= 32'd1) ? 32'd0 : pos_ext - 32'd1;
  assign clamp_idx = (raw_idx > len_ext) ? len_ext : raw_idx;

  assign is_full   = (len_q >= CAP_C);
  assign is_empty  = (len_q == '0);
  assign found_any = found_chain[CAPACITY];

  always_comb begin
    cmd.insert = 1'b0;
    cmd.remove = 1'b0;
    if (state_q == S_APPLY) begin
      cmd.insert = ((op_q == OP_APPEND) || (op_q == OP_INSERT)) && !is_full;
      cmd.remove = (op_q == OP_FIND_REMOVE) && !is_empty;
    end
  end

  assign found_chain[0] = 1'b0;
  assign tap_chain[0]   = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    bole_cell #(
      .IDX (g),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .ins_idx_i (idx_q),
      .len_i     (len_q),
      .key_i     (in_value),
      .load_i    (value_q),
      .left_i    (left_w),
      .right_i   (right_w),
      .found_i   (found_chain[g]),
      .tap_i     (tap_chain[g]),
      .data_o    (cell_data[g]),
      .found_o   (found_chain[g+1]),
      .tap_o     (tap_chain[g+1])
    );
  end

  always_comb begin
    len_d     = len_q;
    status_d  = ST_OK;
    removed_d = '0;
    unique case (op_q)
      OP_APPEND, OP_INSERT: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          len_d = len_q + CW'(1);
        end
      end
      OP_REMOVE_LAST: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          removed_d = tap_chain[CAPACITY];
          len_d     = len_q - CW'(1);
        end
      end
      OP_FIND_REMOVE: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else if (!found_any) begin
          status_d = ST_NOT_FOUND;
        end else begin
          len_d = len_q - CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign len_wide = {{COUNT_W{1'b0}}, len_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          state_q     <= S_IDLE;
          len_q       <= len_d;
          out_valid_q <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= op_e'(s_axis_tuser);
      value_q <= in_value;
      idx_q   <= clamp_idx[IW-1:0];
    end
    if (state_q == S_APPLY) begin
      removed_q <= removed_d;
      status_q  <= status_d;
      count_q   <= len_wide[COUNT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, count_q, removed_q};
  assign m_axis_tuser  = status_q;

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CAP_C)
    else $error("entry count above capacity");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ##1 m_axis_tvalid)
    else $error("no result two cycles after a request");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |-> (len_q == CAP_C))
    else $error("full status with free slots");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_EMPTY)) |-> (len_q == '0))
    else $error("empty status with entries held");

endmodule

/* tb/sv/bole_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bole_checker
// Watches both stream channels of the list engine, keeps its own copy of the
// list, predicts one result per accepted request and compares each result
// transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bole_checker
  import bole_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // value[31:0], position[47:32]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // removed_value[31:0], entry_count[38:32]
  input  logic [1:0]  m_axis_tuser,   // status[1:0]
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [WORD_W-1:0]  removed_value;
    status_e            status;
    logic [COUNT_W-1:0] entry_count;
  } list_result_t;

  logic [WORD_W-1:0] list_words [CAPACITY];
  int                list_len = 0;
  list_result_t      pending_results [$];
  int                fails = 0;
  int                waiting = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;

  // Shift the rear part up by one and place the word at slot
  function automatic void open_slot(int slot, logic [WORD_W-1:0] word);
    int i;
    for (i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
    list_words[slot] = word;
    list_len++;
  endfunction

  function automatic list_result_t predict_list_op(op_e op, logic [WORD_W-1:0] word,
                                                   logic [POS_W-1:0] pos);
    list_result_t res;
    int           i;
    int           hit;
    int           slot;
    res.removed_value = '0;
    res.status        = ST_OK;
    case (op)
      OP_APPEND: begin
        if (list_len >= CAPACITY) res.status = ST_FULL;
        else open_slot(list_len, word);
      end
      OP_REMOVE_LAST: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed_value = list_words[list_len-1];
          list_len--;
        end
      end
      OP_FIND_REMOVE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          hit = -1;
          for (i = 0; i < list_len; i++)
            if (hit < 0 && list_words[i] == word) hit = i;
          if (hit < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            // close the gap left by the first match
            for (i = hit; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
            list_len--;
          end
        end
      end
      default: begin
        slot = (pos <= 1) ? 0 : int'(pos) - 1;
        if (slot > list_len) slot = list_len;
        if (list_len >= CAPACITY) res.status = ST_FULL;
        else open_slot(slot, word);
      end
    endcase
    res.entry_count = list_len[COUNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      list_len = 0;
      pending_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(predict_list_op(op_e'(s_axis_tuser),
                                                  s_axis_tdata[31:0], s_axis_tdata[47:32]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no request outstanding");
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[31:0] !== want.removed_value) begin
            $error("removed_value mismatch: expected %0d, actual %0d",
                   $signed(want.removed_value), $signed(m_axis_tdata[31:0]));
            fails++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, m_axis_tuser);
            fails++;
          end
          if (m_axis_tdata[38:32] !== want.entry_count) begin
            $error("entry_count mismatch: expected %0d, actual %0d",
                   want.entry_count, m_axis_tdata[38:32]);
            fails++;
          end
        end
      end
    end
    waiting = pending_results.size();
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives list requests into the bounded ordered list engine: a directed run
// over the edge cases, then random fill/drain bursts under four back-pressure
// patterns. The checker beside the engine predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import bole_pkg::*;

  localparam int unsigned CAPACITY     = CAPACITY_DEFAULT;
  localparam int          PHASE_ITEMS  = 500;
  localparam int          LIMIT_CYCLES = 400000;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // value[31:0], position[47:32]
  logic [1:0]  s_axis_tuser = '0;   // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // removed_value[31:0], entry_count[38:32]
  logic [1:0]  m_axis_tuser;        // status[1:0]

  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  int          sender_idle_pct = 0;
  int          sink_stall_pct = 0;
  mix_e        mix = MIX_FILL;
  int          burst_left = 0;
  logic [31:0] word_pool [16];

  bounded_ordered_list_engine_unit #(.CAPACITY(CAPACITY)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  bole_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending_count)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("bounded_ordered_list_engine_unit verification failed");
      $finish;
    end
  end

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

  // Entered at a falling edge; returns at the falling edge after the transaction
  task automatic send_request(op_e op, logic [31:0] word, logic [15:0] pos);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, word};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    if ($urandom_range(99) < 70) return word_pool[$urandom_range(15)];
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_position();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 16'($urandom_range(8));
    if (r < 70) return 16'($urandom_range(CAPACITY + 6));
    if (r < 85) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  function automatic op_e pick_op();
    int r;
    logic grow;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:  grow = (r < 85);
      MIX_DRAIN: grow = (r < 20);
      default:   grow = (r < 50);
    endcase
    if (grow) return $urandom_range(1) ? OP_INSERT : OP_APPEND;
    return $urandom_range(1) ? OP_FIND_REMOVE : OP_REMOVE_LAST;
  endfunction

  task automatic run_random_phase(int items);
    int n;
    for (n = 0; n < items; n++) begin
      // rotate fill, balanced, drain so the list swings between empty and full
      if (burst_left == 0) begin
        mix = (mix == MIX_DRAIN) ? MIX_FILL : mix_e'(int'(mix) + 1);
        burst_left = $urandom_range(60, 170);
      end
      burst_left--;
      send_request(pick_op(), pick_word(), pick_position());
    end
  endtask

  initial begin
    word_pool[0] = 32'h0000_0000;
    word_pool[1] = 32'hFFFF_FFFF;
    word_pool[2] = 32'h7FFF_FFFF;
    word_pool[3] = 32'h8000_0000;
    word_pool[4] = 32'h0000_0001;
    for (int k = 5; k < 16; k++) word_pool[k] = $urandom;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list cases, then insert into an empty list with a far position
    send_request(OP_REMOVE_LAST, 32'h1234_5678, 16'h0000);
    send_request(OP_FIND_REMOVE, 32'h0000_0000, 16'h0000);
    send_request(OP_INSERT,      32'h0BAD_F00D, 16'd5);
    send_request(OP_APPEND,      32'h7FFF_FFFF, 16'hFFFF);
    send_request(OP_APPEND,      32'h8000_0000, 16'h0000);
    send_request(OP_INSERT,      32'h0000_0000, 16'd0);
    send_request(OP_INSERT,      32'hFFFF_FFFF, 16'd1);
    send_request(OP_INSERT,      32'h1234_5678, 16'd3);
    send_request(OP_INSERT,      32'hA5A5_A5A5, 16'hFFFF);
    send_request(OP_INSERT,      32'h5A5A_5A5A, 16'd7);
    send_request(OP_APPEND,      32'h8000_0000, 16'h0000);
    send_request(OP_FIND_REMOVE, 32'hDEAD_BEEF, 16'hFFFF);
    send_request(OP_FIND_REMOVE, 32'h8000_0000, 16'h0000);
    send_request(OP_FIND_REMOVE, 32'hFFFF_FFFF, 16'h0000);
    send_request(OP_FIND_REMOVE, 32'h8000_0000, 16'h0000);
    send_request(OP_REMOVE_LAST, 32'h0000_0000, 16'h0000);
    send_request(OP_REMOVE_LAST, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(OP_INSERT,      32'h0000_0001, 16'd2);
    send_request(OP_REMOVE_LAST, 32'h0000_0000, 16'h0000);
    send_request(OP_REMOVE_LAST, 32'h0000_0000, 16'h0000);
    send_request(OP_REMOVE_LAST, 32'h0000_0000, 16'h0000);
    send_request(OP_REMOVE_LAST, 32'h0000_0000, 16'h0000);
    send_request(OP_REMOVE_LAST, 32'h0000_0000, 16'h0000);

    run_random_phase(PHASE_ITEMS);
    sender_idle_pct = 78;
    run_random_phase(PHASE_ITEMS);
    sender_idle_pct = 0;
    sink_stall_pct  = 78;
    run_random_phase(PHASE_ITEMS);
    sender_idle_pct = 25;
    sink_stall_pct  = 25;
    run_random_phase(PHASE_ITEMS);

    s_axis_tvalid <= 1'b0;
    sink_stall_pct = 0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    if (fail_count == 0)
      $display("bounded_ordered_list_engine_unit verification clean");
    else
      $display("bounded_ordered_list_engine_unit verification failed");
    $finish;
  end

endmodule

/* filelist.f */
hdl/bole_pkg.sv
hdl/bole_cell.sv
hdl/bounded_ordered_list_engine_unit.sv
tb/sv/bole_checker.sv
tb/sv/tb_top.sv
